// ----- rtl/aqr_pkg.sv -----
// ----------------------------------------------------------------------------
// aqr_pkg
// Shared widths, defaults and status codes of the abc quality radical block.
// ----------------------------------------------------------------------------
package aqr_pkg;

	localparam int VAL_W       = 32;
	localparam int Q_W         = 21;
	localparam int ST_W        = 2;
	localparam int D_W         = 17;
	localparam int E_W         = 5;
	localparam int Q_SHIFT     = 16;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 56;

	localparam int DEF_PRIME_LIMIT  = 65536;
	localparam int DEF_PRODUCT_BITS = 32;
	localparam int DEF_FRAC_BITS    = 16;

	localparam logic [Q_W-1:0] Q_MAX = 21'h1FFFFF;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_OVF   = 2'd1;
	localparam logic [ST_W-1:0] ST_UNDEF = 2'd2;

endpackage

// ----- rtl/abc_quality_radical.sv -----
// ----------------------------------------------------------------------------
// abc_quality_radical
// Radical of a*b*c and the quality log2(c)/log2(rad) in unsigned Q5.16.
// ----------------------------------------------------------------------------
// One beat on s_axis carries a, b and c; one beat on m_axis carries the
// radical, the quality and a status (0 ok, 1 overflow, 2 undefined).
// s_axis_tready is high only while the sequencer is idle: one item at a time.
// The product is formed on a shared multiplier, then trial division runs by
// 2 and the odd numbers up to PRIME_LIMIT, stopping once d*d exceeds the
// cofactor. Each division step runs on the shared bit-serial divider, so
// the trial loop sets the latency, longest when n is a large prime. Two
// fixed-point logs and a final divide follow.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver still stalls when the next result is done, the
// sequencer holds that result until the register frees.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module abc_quality_radical import aqr_pkg::*; #(
	parameter int PRIME_LIMIT  = DEF_PRIME_LIMIT,
	parameter int PRODUCT_BITS = DEF_PRODUCT_BITS,
	parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// value_a [31:0], value_b [63:32], value_c [95:64]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// radical [31:0], quality_q16 [52:32], status [54:53], zero [55]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int LW  = FRAC_BITS + E_W;
	localparam int NW  = (LW + Q_SHIFT > VAL_W) ? LW + Q_SHIFT : VAL_W;
	localparam int DW  = (LW > D_W) ? LW : D_W;
	localparam int CW  = $clog2(NW + 1);
	localparam int FCW = $clog2(FRAC_BITS);

	typedef enum logic [4:0] {
		S_IDLE, S_MUL_AB, S_CHK_AB, S_MUL_N, S_CHK_N, S_TD_SQ, S_TD_CHK,
		S_TD_START, S_TD_DIV, S_TD_RMUL, S_TD_RMUL_W, S_TAIL, S_TAIL_MUL,
		S_TAIL_W, S_RAD_CHK, S_LOG_NORM, S_LOG_SQ, S_LOG_SQ_W, S_Q_START,
		S_Q_DIV, S_FINISH
	} state_t;

	state_t             state_q;
	logic [VAL_W-1:0]   a_q, b_q, c_q, n_q, rad_q, m_q;
	logic [D_W-1:0]     d_q;
	logic               hit_q;
	logic [E_W-1:0]     e_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [FCW-1:0]     cnt_q;
	logic               lsel_q;
	logic [LW-1:0]      lc_q, lr_q;
	logic [Q_W-1:0]     qual_q;
	logic [ST_W-1:0]    st_q;
	logic               out_valid_q;
	logic [VAL_W-1:0]   out_rad_q;
	logic [Q_W-1:0]     out_qual_q;
	logic [ST_W-1:0]    out_st_q;

	logic [VAL_W-1:0]   mul_a, mul_b;
	logic [2*VAL_W-1:0] prod;
	logic               div_start;
	logic [CW-1:0]      div_steps;
	logic [NW-1:0]      div_dividend;
	logic [DW-1:0]      div_divisor;
	logic               div_done;
	logic [NW-1:0]      div_quot;
	logic [DW-1:0]      div_rem;
	logic [VAL_W:0]     sq;
	logic [FRAC_BITS-1:0] frac_nx;
	logic [VAL_W-1:0]   m_nx;

	aqr_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.product (prod)
	);

	aqr_div #(.NW(NW), .DW(DW), .CW(CW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.steps     (div_steps),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_comb begin
		mul_a = a_q;
		mul_b = b_q;
		unique case (state_q)
			S_MUL_N: begin
				mul_a = n_q;
				mul_b = c_q;
			end
			S_TD_SQ: begin
				mul_a = VAL_W'(d_q);
				mul_b = VAL_W'(d_q);
			end
			S_TD_RMUL: begin
				mul_a = rad_q;
				mul_b = VAL_W'(d_q);
			end
			S_TAIL_MUL: begin
				mul_a = rad_q;
				mul_b = n_q;
			end
			S_LOG_SQ: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			default: begin
				mul_a = a_q;
				mul_b = b_q;
			end
		endcase
	end

	always_comb begin
		div_start    = (state_q == S_TD_START) || (state_q == S_Q_START);
		div_steps    = CW'(VAL_W);
		div_dividend = NW'(n_q) << (NW - VAL_W);
		div_divisor  = DW'(d_q);
		if (state_q == S_Q_START) begin
			div_steps    = CW'(LW + Q_SHIFT);
			div_dividend = NW'({lc_q, {Q_SHIFT{1'b0}}}) << (NW - LW - Q_SHIFT);
			div_divisor  = DW'(lr_q);
		end
	end

	assign sq      = prod[2*VAL_W-1:VAL_W-1];
	assign frac_nx = {frac_q[FRAC_BITS-2:0], sq[VAL_W]};
	assign m_nx    = sq[VAL_W] ? sq[VAL_W:1] : sq[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			n_q         <= '0;
			rad_q       <= '0;
			m_q         <= '0;
			d_q         <= '0;
			hit_q       <= 1'b0;
			e_q         <= '0;
			frac_q      <= '0;
			cnt_q       <= '0;
			lsel_q      <= 1'b0;
			lc_q        <= '0;
			lr_q        <= '0;
			qual_q      <= '0;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
			out_rad_q   <= '0;
			out_qual_q  <= '0;
			out_st_q    <= ST_OK;
		end else begin
			if (state_q == S_FINISH && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						a_q     <= s_axis_tdata[VAL_W-1:0];
						b_q     <= s_axis_tdata[2*VAL_W-1:VAL_W];
						c_q     <= s_axis_tdata[3*VAL_W-1:2*VAL_W];
						qual_q  <= '0;
						state_q <= S_MUL_AB;
					end
				end
				S_MUL_AB: state_q <= S_CHK_AB;
				S_CHK_AB: begin
					if (a_q == '0 || b_q == '0 || c_q == '0) begin
						rad_q   <= '0;
						st_q    <= ST_UNDEF;
						state_q <= S_FINISH;
					end else if (prod[2*VAL_W-1:PRODUCT_BITS] != '0) begin
						rad_q   <= '0;
						st_q    <= ST_OVF;
						state_q <= S_FINISH;
					end else begin
						n_q     <= prod[VAL_W-1:0];
						state_q <= S_MUL_N;
					end
				end
				S_MUL_N: state_q <= S_CHK_N;
				S_CHK_N: begin
					if (prod[2*VAL_W-1:PRODUCT_BITS] != '0) begin
						rad_q   <= '0;
						st_q    <= ST_OVF;
						state_q <= S_FINISH;
					end else begin
						n_q     <= prod[VAL_W-1:0];
						rad_q   <= VAL_W'(1);
						d_q     <= D_W'(2);
						hit_q   <= 1'b0;
						state_q <= S_TD_SQ;
					end
				end
				S_TD_SQ: state_q <= S_TD_CHK;
				S_TD_CHK: begin
					if (d_q > D_W'(PRIME_LIMIT) || prod > (2*VAL_W)'(n_q)) begin
						state_q <= S_TAIL;
					end else begin
						state_q <= S_TD_START;
					end
				end
				S_TD_START: state_q <= S_TD_DIV;
				S_TD_DIV: begin
					if (div_done) begin
						if (div_rem == '0) begin
							n_q   <= div_quot[VAL_W-1:0];
							hit_q <= 1'b1;
							state_q <= hit_q ? S_TD_START : S_TD_RMUL;
						end else begin
							hit_q   <= 1'b0;
							d_q     <= d_q + ((d_q == D_W'(2)) ? D_W'(1) : D_W'(2));
							state_q <= S_TD_SQ;
						end
					end
				end
				S_TD_RMUL: state_q <= S_TD_RMUL_W;
				S_TD_RMUL_W: begin
					rad_q   <= prod[VAL_W-1:0];
					state_q <= S_TD_START;
				end
				S_TAIL: state_q <= (n_q > VAL_W'(1)) ? S_TAIL_MUL : S_RAD_CHK;
				S_TAIL_MUL: state_q <= S_TAIL_W;
				S_TAIL_W: begin
					rad_q   <= prod[VAL_W-1:0];
					state_q <= S_RAD_CHK;
				end
				S_RAD_CHK: begin
					if (rad_q <= VAL_W'(1)) begin
						st_q    <= ST_UNDEF;
						state_q <= S_FINISH;
					end else begin
						st_q    <= ST_OK;
						m_q     <= c_q;
						e_q     <= E_W'(VAL_W - 1);
						frac_q  <= '0;
						lsel_q  <= 1'b0;
						state_q <= S_LOG_NORM;
					end
				end
				S_LOG_NORM: begin
					if (m_q[VAL_W-1]) begin
						cnt_q   <= '0;
						state_q <= S_LOG_SQ;
					end else begin
						m_q <= {m_q[VAL_W-2:0], 1'b0};
						e_q <= e_q - E_W'(1);
					end
				end
				S_LOG_SQ: state_q <= S_LOG_SQ_W;
				S_LOG_SQ_W: begin
					cnt_q <= cnt_q + FCW'(1);
					if (cnt_q == FCW'(FRAC_BITS - 1)) begin
						if (!lsel_q) begin
							lc_q    <= {e_q, frac_nx};
							m_q     <= rad_q;
							e_q     <= E_W'(VAL_W - 1);
							frac_q  <= '0;
							lsel_q  <= 1'b1;
							state_q <= S_LOG_NORM;
						end else begin
							lr_q    <= {e_q, frac_nx};
							state_q <= S_Q_START;
						end
					end else begin
						frac_q  <= frac_nx;
						m_q     <= m_nx;
						state_q <= S_LOG_SQ;
					end
				end
				S_Q_START: state_q <= S_Q_DIV;
				S_Q_DIV: begin
					if (div_done) begin
						qual_q  <= (div_quot > NW'(Q_MAX)) ? Q_MAX : div_quot[Q_W-1:0];
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || m_axis_tready) begin
						out_rad_q   <= rad_q;
						out_qual_q  <= qual_q;
						out_st_q    <= st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_st_q, out_qual_q, out_rad_q};

endmodule

// ----- rtl/aqr_mul.sv -----
// ----------------------------------------------------------------------------
// aqr_mul
// Shared 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module aqr_mul import aqr_pkg::*; (
	input  logic               clk,
	input  logic [VAL_W-1:0]   op_a,
	input  logic [VAL_W-1:0]   op_b,
	output logic [2*VAL_W-1:0] product
);

	always_ff @(posedge clk) begin
		product <= op_a * op_b;
	end

endmodule

// ----- rtl/aqr_div.sv -----
// ----------------------------------------------------------------------------
// aqr_div
// Shared restoring divider, one quotient bit per cycle. The dividend is
// aligned to the top; steps gives the number of quotient bits to form.
// ----------------------------------------------------------------------------
module aqr_div import aqr_pkg::*; #(
	parameter int NW = 37,
	parameter int DW = 21,
	parameter int CW = $clog2(NW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] steps,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder
);

	logic [NW-1:0] work_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, work_q[NW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				work_q <= dividend;
				rem_q  <= '0;
				div_q  <= divisor;
				cnt_q  <= steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				work_q <= {work_q[NW-2:0], ge};
				rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				cnt_q  <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/aqr_checker.sv -----
// ----------------------------------------------------------------------------
// aqr_checker
// Port-level checks of abc_quality_radical, bound to the top level.
// ----------------------------------------------------------------------------
module aqr_checker import aqr_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled beat changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[54:53] != 2'd3)
		else $error("bad status");

	a_quality_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[54:53] != ST_OK |-> m_axis_tdata[52:32] == '0)
		else $error("quality set with nonzero status");

	a_ovf_radical: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[54:53] == ST_OVF |-> m_axis_tdata[31:0] == '0)
		else $error("radical set on overflow");

endmodule

bind abc_quality_radical aqr_checker u_aqr_checker (.*);

// ----- tb/abc_quality_radical_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// abc_quality_radical_chk
// Watches both streams of the radical block, predicts each result from the
// accepted a, b, c triple and compares radical, quality and status in order.
// ----------------------------------------------------------------------------
module abc_quality_radical_chk import aqr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output int                     outstanding,
	output int                     errors
);

	localparam int FRAC = DEF_FRAC_BITS;

	logic [OUT_TDATA_W-1:0] result_q[$];

	initial begin
		outstanding = 0;
		errors = 0;
	end

	function automatic longint unsigned fixed_log2(longint unsigned x);
		int unsigned e;
		longint unsigned m;
		longint unsigned frac;
		e = 0;
		frac = 0;
		while (e < 31 && (x >> (e + 1)) != 0)
			e++;
		m = x << (31 - e);
		for (int i = 0; i < FRAC; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (longint'(e) << FRAC) | frac;
	endfunction

	function automatic longint unsigned trial_radical(longint unsigned n);
		longint unsigned r;
		longint unsigned d;
		r = 1;
		for (d = 2; d <= DEF_PRIME_LIMIT && d * d <= n; d++) begin
			if (n % d == 0) begin
				r = r * d;
				while (n % d == 0)
					n = n / d;
			end
		end
		if (n > 1)
			r = r * n;
		return r;
	endfunction

	function automatic logic [OUT_TDATA_W-1:0] predict_result(logic [IN_TDATA_W-1:0] beat);
		longint unsigned a, b, c, ab, n, r, q;
		logic [VAL_W-1:0] rad;
		logic [Q_W-1:0]   qual;
		logic [ST_W-1:0]  st;
		a = beat[31:0];
		b = beat[63:32];
		c = beat[95:64];
		rad = '0;
		qual = '0;
		st = ST_OK;
		ab = a * b;
		n = ab * c;
		if (a == 0 || b == 0 || c == 0) begin
			st = ST_UNDEF;
		end else if (ab >= (64'd1 << DEF_PRODUCT_BITS) || n >= (64'd1 << DEF_PRODUCT_BITS)) begin
			st = ST_OVF;
		end else begin
			r = trial_radical(n);
			rad = r[VAL_W-1:0];
			if (r <= 1) begin
				st = ST_UNDEF;
			end else begin
				q = (fixed_log2(c) << Q_SHIFT) / fixed_log2(r);
				qual = (q > Q_MAX) ? Q_MAX : q[Q_W-1:0];
			end
		end
		return {1'b0, st, qual, rad};
	endfunction

	always @(posedge clk) begin
		logic [OUT_TDATA_W-1:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				result_q = {result_q, predict_result(s_axis_tdata)};
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t unexpected result beat %h", $realtime, m_axis_tdata);
				end else begin
					want = result_q.pop_front();
					if (want !== m_axis_tdata) begin
						errors++;
						if (errors <= 10)
							$display("%0t mismatch rad %0d/%0d q %0d/%0d st %0d/%0d pad %b (exp/act)",
								$realtime, want[31:0], m_axis_tdata[31:0],
								want[52:32], m_axis_tdata[52:32],
								want[54:53], m_axis_tdata[54:53], m_axis_tdata[55]);
					end
				end
			end
			outstanding = result_q.size();
		end
	end

endmodule

// ----- tb/abc_quality_radical_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// abc_quality_radical_tb
// Drives a, b, c triples into the radical block: directed corners (unit and
// zero terms, both overflow points, full 32-bit product, a large prime) and
// then mostly smooth triples, overflow and zero-a noise, with random stalls.
// ----------------------------------------------------------------------------
module abc_quality_radical_tb;
	import aqr_pkg::*;

	localparam int N_RANDOM = 100;
	localparam int CALM_TAIL = 20;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   calm = 1'b0;
	int                     outstanding;
	int                     errors;

	int unsigned small_primes[16] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
		97, 251};

	always #4 clk = ~clk;

	abc_quality_radical dut (.*);

	abc_quality_radical_chk chk (.*);

	function automatic logic [31:0] smooth_term();
		longint unsigned t;
		longint unsigned p;
		t = 1;
		repeat ($urandom_range(0, 6)) begin
			p = small_primes[$urandom_range(0, 15)];
			if (t * p < 64'h1_0000_0000)
				t = t * p;
		end
		if ($urandom_range(0, 2) == 0) begin
			p = $urandom_range(1, 4095);
			if (t * p < 64'h1_0000_0000)
				t = t * p;
		end
		return t[31:0];
	endfunction

	task automatic send_triple(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c, b, a};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		int kind;
		int lap;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_triple(32'd1, 32'd1, 32'd1);
		send_triple(32'd0, 32'd5, 32'd7);
		send_triple(32'd3, 32'd0, 32'd7);
		send_triple(32'd3, 32'd5, 32'd0);
		send_triple(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_triple(32'hFFFF_FFFF, 32'd2, 32'd1);
		send_triple(32'd65535, 32'd65535, 32'd2);
		send_triple(32'd65535, 32'd65537, 32'd1);
		send_triple(32'd1, 32'd1, 32'hFFFF_FFFF);
		send_triple(32'hFFFF_FFFF, 32'd1, 32'd1);
		send_triple(32'd1, 32'd1, 32'h8000_0000);
		send_triple(32'd2, 32'd3, 32'd5);
		send_triple(32'd1, 32'd1, 32'd4294967291);
		send_triple(32'd7, 32'd1, 32'd1);
		send_triple(32'd1, 32'd65521, 32'd65521);
		send_triple(32'd1024, 32'd1024, 32'd1024);

		// hold off until the pipe drains
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);

		for (lap = 0; lap < N_RANDOM; lap++) begin
			if (lap == N_RANDOM - CALM_TAIL)
				calm <= 1'b1;
			kind = $urandom_range(0, 19);
			if (kind < 13)
				send_triple(smooth_term(), smooth_term(), smooth_term());
			else if (kind < 19)
				send_triple($urandom() | 32'h8000_0000, $urandom() | 32'd2, $urandom());
			else
				send_triple(32'd0, $urandom(), $urandom());
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		while (outstanding != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#400ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
